>>> rtl/core/spa_pkg.sv
// Shared constants, result selector codes and controller/datapath interface types.
package spa_pkg;

  localparam int SPP         = 12;
  localparam int CNT_W       = 4;
  localparam int HR_W        = 8;
  localparam int HR_SUM_W    = 12;
  localparam int VAL_W       = 16;
  localparam int SUM_W       = 20;
  localparam int TS_W        = 32;
  localparam int SEQ_W       = 8;
  localparam int NUM_AVG     = 8;
  localparam int SEL_W       = 3;
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 168;

  localparam logic [SEL_W-1:0] SEL_HR   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_TEMP = 3'd1;
  localparam logic [SEL_W-1:0] SEL_AX   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_AY   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_AZ   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_GX   = 3'd5;
  localparam logic [SEL_W-1:0] SEL_GY   = 3'd6;
  localparam logic [SEL_W-1:0] SEL_GZ   = 3'd7;

  typedef struct packed {
    logic             accept;
    logic             first;
    logic             div_start;
    logic             div_store;
    logic [SEL_W-1:0] sel;
    logic             load;
  } spa_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } spa_status_t;

endpackage

>>> rtl/core/spa_div.sv
// Bit-serial divider that forms a mean rounded to nearest with ties away from zero.
module spa_div
  import spa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0]        cnt,
  output logic                    busy,
  output logic                    done,
  output logic [VAL_W-1:0]        quo
);

  localparam int NUM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int DEN_W  = CNT_W + 1;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  work_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;

  logic [SUM_W-1:0]  mag;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [VAL_W-1:0]  q;

  assign mag   = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign trial = {rem_r, work_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign q     = work_r[VAL_W-1:0];
  assign quo   = neg_r ? (~q + VAL_W'(1)) : q;
  assign busy  = busy_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= {mag, 1'b0} + NUM_W'(cnt);
      den_r  <= {cnt, 1'b0};
      rem_r  <= '0;
      neg_r  <= sum[SUM_W-1];
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[DEN_W-1:0];
      end
      work_r <= {work_r[NUM_W-2:0], fits};
    end
  end

endmodule

>>> rtl/core/spa_datapath.sv
// Page accumulators, time span, mean slots and output register of the averager.
module spa_datapath
  import spa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  spa_cmd_t               cmd,
  output spa_status_t            status,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AXES    = 6;
  localparam int AXIS_LO = HR_W + VAL_W;
  localparam int TS_LO   = AXIS_LO + AXES * VAL_W;
  localparam int PAD_W   = OUT_TDATA_W - (SEQ_W + TS_W + HR_W + CNT_W + 7 * VAL_W);

  logic [HR_SUM_W-1:0]     hr_sum_r, hr_sum_nxt;
  logic [CNT_W-1:0]        hr_cnt_r, hr_cnt_nxt;
  logic signed [SUM_W-1:0] temp_sum_r, temp_sum_nxt;
  logic [CNT_W-1:0]        temp_cnt_r, temp_cnt_nxt;
  logic signed [SUM_W-1:0] axis_sum_r [AXES];
  logic signed [SUM_W-1:0] axis_sum_nxt [AXES];
  logic [SEQ_W-1:0]        page_r;
  logic [TS_W-1:0]         first_ts_r;
  logic [TS_W-1:0]         span_r;
  logic [VAL_W-1:0]        avg_r [NUM_AVG];
  logic [OUT_TDATA_W-1:0]  out_tdata_r;

  logic [HR_W-1:0]         hr;
  logic signed [VAL_W-1:0] temp;
  logic [TS_W-1:0]         ts;
  logic [TS_W-1:0]         first_sel;
  logic signed [SUM_W-1:0] div_sum;
  logic [CNT_W-1:0]        div_cnt;
  logic [VAL_W-1:0]        div_quo;
  logic                    div_busy;
  logic                    div_done;

  assign hr        = in_tdata[HR_W-1:0];
  assign temp      = in_tdata[HR_W +: VAL_W];
  assign ts        = in_tdata[TS_LO +: TS_W];
  assign first_sel = cmd.first ? ts : first_ts_r;

  always_comb begin
    hr_sum_nxt   = hr_sum_r;
    hr_cnt_nxt   = hr_cnt_r;
    temp_sum_nxt = temp_sum_r;
    temp_cnt_nxt = temp_cnt_r;
    for (int i = 0; i < AXES; i++) begin
      axis_sum_nxt[i] = axis_sum_r[i];
    end
    if (cmd.load) begin
      hr_sum_nxt   = '0;
      hr_cnt_nxt   = '0;
      temp_sum_nxt = '0;
      temp_cnt_nxt = '0;
      for (int i = 0; i < AXES; i++) begin
        axis_sum_nxt[i] = '0;
      end
    end else if (cmd.accept) begin
      if (hr != '0) begin
        hr_sum_nxt = hr_sum_r + HR_SUM_W'(hr);
        hr_cnt_nxt = hr_cnt_r + CNT_W'(1);
      end
      if (temp != '0) begin
        temp_sum_nxt = temp_sum_r + SUM_W'(temp);
        temp_cnt_nxt = temp_cnt_r + CNT_W'(1);
      end
      for (int i = 0; i < AXES; i++) begin
        axis_sum_nxt[i] = axis_sum_r[i]
                        + SUM_W'($signed(in_tdata[AXIS_LO + i * VAL_W +: VAL_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hr_sum_r   <= '0;
      hr_cnt_r   <= '0;
      temp_sum_r <= '0;
      temp_cnt_r <= '0;
      page_r     <= '0;
      for (int i = 0; i < AXES; i++) begin
        axis_sum_r[i] <= '0;
      end
    end else begin
      hr_sum_r   <= hr_sum_nxt;
      hr_cnt_r   <= hr_cnt_nxt;
      temp_sum_r <= temp_sum_nxt;
      temp_cnt_r <= temp_cnt_nxt;
      for (int i = 0; i < AXES; i++) begin
        axis_sum_r[i] <= axis_sum_nxt[i];
      end
      if (cmd.load) begin
        page_r <= page_r + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (cmd.first) begin
        first_ts_r <= ts;
      end
      span_r <= (ts >= first_sel) ? (ts - first_sel) : '0;
    end
    if (cmd.div_store) begin
      avg_r[cmd.sel] <= (div_cnt == '0) ? '0 : div_quo;
    end
    if (cmd.load) begin
      out_tdata_r <= {{PAD_W{1'b0}},
                      avg_r[SEL_GZ], avg_r[SEL_GY], avg_r[SEL_GX],
                      avg_r[SEL_AZ], avg_r[SEL_AY], avg_r[SEL_AX],
                      avg_r[SEL_TEMP], temp_cnt_r,
                      avg_r[SEL_HR][HR_W-1:0], span_r, page_r};
    end
  end

  always_comb begin
    div_sum = axis_sum_r[0];
    div_cnt = CNT_W'(SPP);
    case (cmd.sel)
      SEL_HR: begin
        div_sum = SUM_W'(hr_sum_r);
        div_cnt = hr_cnt_r;
      end
      SEL_TEMP: begin
        div_sum = temp_sum_r;
        div_cnt = temp_cnt_r;
      end
      SEL_AX: div_sum = axis_sum_r[0];
      SEL_AY: div_sum = axis_sum_r[1];
      SEL_AZ: div_sum = axis_sum_r[2];
      SEL_GX: div_sum = axis_sum_r[3];
      SEL_GY: div_sum = axis_sum_r[4];
      SEL_GZ: div_sum = axis_sum_r[5];
      default: div_sum = axis_sum_r[0];
    endcase
  end

  spa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .sum   (div_sum),
    .cnt   (div_cnt),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign out_tdata       = out_tdata_r;

endmodule

>>> rtl/core/spa_ctrl.sv
// Controller that counts page samples, sequences the eight means and hands off results.
module spa_ctrl
  import spa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  spa_status_t status,
  output spa_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_LOAD
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SEL_W-1:0] sel_r;
  logic             out_valid_r;

  assign in_tready     = (state_r == ST_ACCUM);
  assign out_tvalid    = out_valid_r;
  assign cmd.accept    = in_tvalid && in_tready;
  assign cmd.first     = (cnt_r == '0);
  assign cmd.div_start = (state_r == ST_DIV_START);
  assign cmd.div_store = (state_r == ST_DIV_WAIT) && status.div_done;
  assign cmd.sel       = sel_r;
  assign cmd.load      = (state_r == ST_LOAD) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      cnt_r       <= '0;
      sel_r       <= SEL_HR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load || (out_valid_r && !out_tready);
      unique case (state_r)
        ST_ACCUM: begin
          if (cmd.accept) begin
            if (cnt_r == CNT_W'(SPP - 1)) begin
              cnt_r   <= '0;
              sel_r   <= SEL_HR;
              state_r <= ST_DIV_START;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        ST_DIV_START: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (status.div_done) begin
            if (sel_r == SEL_GZ) begin
              state_r <= ST_LOAD;
            end else begin
              sel_r   <= sel_r + SEL_W'(1);
              state_r <= ST_DIV_START;
            end
          end
        end
        ST_LOAD: begin
          if (cmd.load) begin
            state_r <= ST_ACCUM;
          end
        end
        default: state_r <= ST_ACCUM;
      endcase
    end
  end

endmodule

>>> rtl/core/sensor_page_averager_unit.sv
// Sensor page averager: summarizes each page of twelve samples into one result.
//
// The input stream carries one sensor sample per transaction. Every twelfth
// sample closes a page, and one result transaction follows with the page
// sequence number, the timestamp span and the rounded means of the page.
// Samples are taken one per cycle while a page fills. After the closing
// sample the input is held off while a shared bit-serial divider forms the
// eight means one after another before the result is loaded. The result sits
// in an output register and the next page fills while it waits. If the
// receiver still holds off the previous result when a new page completes,
// the block waits with in_tready low until that result is taken. Reset
// clears the page, the sequence number and the output valid flag; no clearing
// pass is needed.
module sensor_page_averager_unit
  import spa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // heart_rate, temperature, accel_x, accel_y, accel_z, gyro_x, gyro_y,
  // gyro_z, timestamp_ms
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // page_sequence, time_span_ms, avg_heart_rate, temp_count, avg_temperature,
  // avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  spa_cmd_t    cmd;
  spa_status_t status;

  spa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  spa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_tvalid || out_tready))
    else $error("result loaded over an untaken result");

  a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.load))
    else $error("result valid raised without a load");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_busy |-> !cmd.accept)
    else $error("sample accepted while means are formed");

endmodule

>>> sim/tb_sensor_page_averager_unit.sv
// Self-checking testbench for the sensor page averager, with a built-in predictor of page results.
`timescale 1ns / 100ps

module tb_sensor_page_averager_unit;
  import spa_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD  = 3000;
  localparam int TAIL       = 250;

  typedef enum int {
    FILL_FULL,
    FILL_SMALL,
    FILL_EXTREME
  } fill_kind_t;

  typedef struct packed {
    logic [31:0]        timestamp_ms;
    logic signed [15:0] gyro_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] temperature;
    logic [7:0]         heart_rate;
  } sample_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic signed [15:0] avg_gyro_z;
    logic signed [15:0] avg_gyro_y;
    logic signed [15:0] avg_gyro_x;
    logic signed [15:0] avg_accel_z;
    logic signed [15:0] avg_accel_y;
    logic signed [15:0] avg_accel_x;
    logic signed [15:0] avg_temperature;
    logic [3:0]         temp_count;
    logic [7:0]         avg_heart_rate;
    logic [31:0]        time_span_ms;
    logic [7:0]         page_sequence;
  } page_summary_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  page_summary_t expected_pages[$];
  int            error_count = 0;
  int            hold_request = 0;
  int            burst_left = 0;
  bit            no_gaps = 1'b0;

  // Predicted page state.
  int          page_fill;
  logic [7:0]  page_index;
  logic [31:0] page_first_ts;
  int          hr_total;
  int          hr_readings;
  int          temp_total;
  int          temp_readings;
  int          accel_total[3];
  int          gyro_total[3];

  sensor_page_averager_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int rounded_mean(input int total, input int n);
    int mag;
    int q;
    if (n == 0) return 0;
    mag = (total < 0) ? -total : total;
    q = (2 * mag + n) / (2 * n);
    return (total < 0) ? -q : q;
  endfunction

  task automatic clear_page_sums();
    page_fill = 0;
    hr_total = 0;
    hr_readings = 0;
    temp_total = 0;
    temp_readings = 0;
    for (int i = 0; i < 3; i++) begin
      accel_total[i] = 0;
      gyro_total[i] = 0;
    end
  endtask

  task automatic accumulate_sample(input sample_t s);
    page_summary_t p;
    int temp_val;
    temp_val = s.temperature;
    if (page_fill == 0) page_first_ts = s.timestamp_ms;
    if (s.heart_rate != 8'd0) begin
      hr_total += s.heart_rate;
      hr_readings++;
    end
    if (temp_val != 0) begin
      temp_total += temp_val;
      temp_readings++;
    end
    accel_total[0] += int'(s.accel_x);
    accel_total[1] += int'(s.accel_y);
    accel_total[2] += int'(s.accel_z);
    gyro_total[0] += int'(s.gyro_x);
    gyro_total[1] += int'(s.gyro_y);
    gyro_total[2] += int'(s.gyro_z);
    page_fill++;
    if (page_fill < SPP) return;
    p = '0;
    p.page_sequence = page_index;
    p.time_span_ms = (s.timestamp_ms >= page_first_ts) ? s.timestamp_ms - page_first_ts : 32'd0;
    p.avg_heart_rate = 8'(rounded_mean(hr_total, hr_readings));
    p.temp_count = 4'(temp_readings);
    p.avg_temperature = 16'(rounded_mean(temp_total, temp_readings));
    p.avg_accel_x = 16'(rounded_mean(accel_total[0], SPP));
    p.avg_accel_y = 16'(rounded_mean(accel_total[1], SPP));
    p.avg_accel_z = 16'(rounded_mean(accel_total[2], SPP));
    p.avg_gyro_x = 16'(rounded_mean(gyro_total[0], SPP));
    p.avg_gyro_y = 16'(rounded_mean(gyro_total[1], SPP));
    p.avg_gyro_z = 16'(rounded_mean(gyro_total[2], SPP));
    expected_pages.push_back(p);
    page_index = page_index + 8'd1;
    clear_page_sums();
  endtask

  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (no_gaps || $urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(30, 250);
      else gap = $urandom_range(1, 25);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= s;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    accumulate_sample(s);
  endtask

  function automatic logic [15:0] pick_axis(input fill_kind_t kind);
    case (kind)
      FILL_SMALL: return 16'($signed($urandom_range(0, 6)) - 3);
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t make_sample(input fill_kind_t kind, input logic [31:0] ts);
    sample_t s;
    s.timestamp_ms = ts;
    s.heart_rate = ($urandom_range(0, 4) == 0) ? 8'd0 :
                   (kind == FILL_SMALL) ? 8'($urandom_range(1, 3)) : 8'($urandom);
    s.temperature = ($urandom_range(0, 4) == 0) ? 16'd0 : pick_axis(kind);
    s.accel_x = pick_axis(kind);
    s.accel_y = pick_axis(kind);
    s.accel_z = pick_axis(kind);
    s.gyro_x = pick_axis(kind);
    s.gyro_y = pick_axis(kind);
    s.gyro_z = pick_axis(kind);
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("Mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : page_checker
    page_summary_t got;
    page_summary_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pages.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected result transaction, page_sequence 0x%0h", got.page_sequence);
      end else begin
        want = expected_pages.pop_front();
        check_field("page_sequence", want.page_sequence, got.page_sequence);
        check_field("time_span_ms", want.time_span_ms, got.time_span_ms);
        check_field("avg_heart_rate", want.avg_heart_rate, got.avg_heart_rate);
        check_field("temp_count", want.temp_count, got.temp_count);
        check_field("avg_temperature", want.avg_temperature, got.avg_temperature);
        check_field("avg_accel_x", want.avg_accel_x, got.avg_accel_x);
        check_field("avg_accel_y", want.avg_accel_y, got.avg_accel_y);
        check_field("avg_accel_z", want.avg_accel_z, got.avg_accel_z);
        check_field("avg_gyro_x", want.avg_gyro_x, got.avg_gyro_x);
        check_field("avg_gyro_y", want.avg_gyro_y, got.avg_gyro_y);
        check_field("avg_gyro_z", want.avg_gyro_z, got.avg_gyro_z);
      end
    end
  end

  initial begin : result_receiver
    int mode;
    int span;
    int hold;
    int period;
    int phase;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      period = $urandom_range(2, 9);
      phase = 0;
      repeat (span) begin
        @(posedge clk);
        if (hold_request > 0) begin
          hold = hold_request;
          hold_request = 0;
          out_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        phase++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 7) == 0);
          default: out_tready <= (phase % period == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_extreme_pages();
    sample_t s;
    for (int i = 0; i < SPP; i++) begin
      s.timestamp_ms = (i == SPP - 1) ? 32'hFFFF_FFFF : 32'(i * 1000);
      s.heart_rate = 8'd255;
      s.temperature = 16'sh7FFF;
      s.accel_x = 16'sh7FFF;
      s.accel_y = 16'sh7FFF;
      s.accel_z = 16'sh7FFF;
      s.gyro_x = 16'sh7FFF;
      s.gyro_y = 16'sh7FFF;
      s.gyro_z = 16'sh7FFF;
      send_sample(s);
    end
    // No heart rate, no temperature and a timestamp that wraps backward.
    for (int i = 0; i < SPP; i++) begin
      s.timestamp_ms = 32'hFFFF_FFF0 + 32'(i * 3);
      s.heart_rate = 8'd0;
      s.temperature = 16'sh0000;
      s.accel_x = 16'sh8000;
      s.accel_y = 16'sh8000;
      s.accel_z = 16'sh8000;
      s.gyro_x = 16'sh8000;
      s.gyro_y = 16'sh8000;
      s.gyro_z = 16'sh8000;
      send_sample(s);
    end
  endtask

  task automatic send_random_page();
    fill_kind_t  kind;
    int          style;
    logic [31:0] ts;
    style = $urandom_range(0, 9);
    kind = (style >= 6 && style <= 7) ? FILL_SMALL : (style == 8) ? FILL_EXTREME : FILL_FULL;
    ts = $urandom;
    for (int i = 0; i < SPP; i++) begin
      if (style == 9) ts = $urandom;
      else if (i > 0) ts = ts + 32'($urandom_range(0, 20));
      send_sample(make_sample(kind, ts));
    end
  endtask

  task automatic test_output_backpressure();
    hold_request = LONG_HOLD;
    no_gaps = 1'b1;
    burst_left = 0;
    repeat (3) send_random_page();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_pages(input int pages);
    repeat (pages) send_random_page();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    page_index = 8'd0;
    page_first_ts = 32'd0;
    clear_page_sums();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_pages();
    test_output_backpressure();
    test_random_pages(70);
    in_tvalid <= 1'b0;
    while (expected_pages.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/spa_pkg.sv
rtl/core/spa_div.sv
rtl/core/spa_datapath.sv
rtl/core/spa_ctrl.sv
rtl/core/sensor_page_averager_unit.sv
sim/tb_sensor_page_averager_unit.sv
